// ----- sv/mqrx_pkg.sv -----
package mqrx_pkg;

    localparam int MAX_LENGTH_BYTES_DEF = 4;

    localparam int KA_W    = 24;
    localparam int CNT_W   = 25;
    localparam int LEN_W   = 28;
    localparam int TLEN_W  = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KA_W-1:0]  KA_RESET = 24'd15000;
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    // packet type nibbles
    localparam logic [3:0] T_NONE     = 4'd0;
    localparam logic [3:0] T_PUBLISH  = 4'd3;
    localparam logic [3:0] T_PINGREQ  = 4'd12;
    localparam logic [3:0] T_PINGRESP = 4'd13;

    // register index taken from the word address
    localparam logic REG_KEEPALIVE = 1'b0;

    typedef enum logic [1:0] {
        REQ_BYTE    = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_SENT    = 2'd2,
        REQ_CONNECT = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_PINGREQ  = 3'd1,
        ACT_PINGRESP = 3'd2,
        ACT_PUB_HEAD = 3'd3,
        ACT_PUB_BYTE = 3'd4,
        ACT_DROP     = 3'd5,
        ACT_MALFORM  = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_LEN  = 3'd1,
        PH_THI  = 3'd2,
        PH_TLO  = 3'd3,
        PH_FWD  = 3'd4,
        PH_SKIP = 3'd5
    } t_phase;

    typedef struct packed {
        t_action           action;
        logic [3:0]        packet_type;
        logic [TLEN_W-1:0] topic_length;
        logic [LEN_W-1:0]  payload_length;
        logic [7:0]        data_byte;
        logic              last;
    } t_result;

endpackage

// ----- sv/mqrx_if.sv -----
interface mqrx_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, req_type, rx_byte, input ready);
    modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface mqrx_res_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  action;
    logic [3:0]                  packet_type;
    logic [mqrx_pkg::TLEN_W-1:0] topic_length;
    logic [mqrx_pkg::LEN_W-1:0]  payload_length;
    logic [7:0]                  data_byte;
    logic                        last;

    modport source (output valid, action, packet_type, topic_length, payload_length,
                    data_byte, last, input ready);
    modport sink   (input valid, action, packet_type, topic_length, payload_length,
                    data_byte, last, output ready);
endinterface

// ----- sv/mqrx_regs.sv -----
module mqrx_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqrx_pkg::PADDR_W-1:0] paddr,
    input  logic [mqrx_pkg::PDATA_W-1:0] pwdata,
    output logic [mqrx_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [mqrx_pkg::KA_W-1:0]    o_keepalive_ticks
);

    logic [mqrx_pkg::KA_W-1:0] r_keepalive;
    logic                      w_sel_ka;

    assign pready   = 1'b1;
    assign w_sel_ka = (paddr[mqrx_pkg::PADDR_W-1] == mqrx_pkg::REG_KEEPALIVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive <= mqrx_pkg::KA_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_ka) begin
            r_keepalive <= pwdata[mqrx_pkg::KA_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_ka) begin
            prdata = {{(mqrx_pkg::PDATA_W - mqrx_pkg::KA_W){1'b0}}, r_keepalive};
        end
    end

    assign o_keepalive_ticks = r_keepalive;

endmodule

// ----- sv/mqtt_rx_parser_keepalive_unit.sv -----
// An accepted request's result reaches o_res through the input register, then the result
//   register; requests that cause no result leave o_res untouched.
// Throughput: one request per cycle, set by the single-pass parser/keepalive update
//   between the input and result registers; o_res back-pressure stalls the input side.
// Reset (i_rst_n low, synchronous): link down, no ping pending, idle counters and parser
//   cleared, both pipeline registers empty, keepalive_ticks back to 15000.
module mqtt_rx_parser_keepalive_unit #(
    parameter int MAX_LENGTH_BYTES = mqrx_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mqrx_req_if.sink                     i_req,
    mqrx_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mqrx_pkg::PADDR_W-1:0] paddr,
    input  logic [mqrx_pkg::PDATA_W-1:0] pwdata,
    output logic [mqrx_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int CW = mqrx_pkg::CNT_W;
    localparam int LW = mqrx_pkg::LEN_W;
    localparam int TW = mqrx_pkg::TLEN_W;
    localparam int KW = mqrx_pkg::KA_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [KW-1:0] w_keepalive;

    mqrx_regs u_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_keepalive_ticks (w_keepalive)
    );

    // ------------------------------------------------------------------
    // Input register: hold one request until the parser consumes it
    // ------------------------------------------------------------------
    logic              r_in_v;
    mqrx_pkg::t_req    r_in_req;
    logic [7:0]        r_in_byte;

    logic              r_out_v;
    mqrx_pkg::t_result r_out;

    logic              w_fire;
    logic              w_in_ready;

    // consume the held request when the result register is free or draining
    assign w_fire     = r_in_v && (!r_out_v || o_res.ready);
    assign w_in_ready = !r_in_v || w_fire;
    assign i_req.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_ready) begin
            r_in_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_in_ready) begin
            r_in_req  <= mqrx_pkg::t_req'(i_req.req_type);
            r_in_byte <= i_req.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Link, keepalive and parser state
    // ------------------------------------------------------------------
    logic                  r_link_up,    n_link_up;
    logic                  r_ping,       n_ping;
    logic [CW-1:0]         r_rx_cnt,     n_rx_cnt;
    logic [CW-1:0]         r_tx_cnt,     n_tx_cnt;
    mqrx_pkg::t_phase      r_phase,      n_phase;
    logic [3:0]            r_type,       n_type;
    logic [LW-1:0]         r_len,        n_len;
    logic [1:0]            r_idx,        n_idx;
    logic [7:0]            r_thi,        n_thi;

    mqrx_pkg::t_result     w_res;
    logic                  w_res_valid;

    // shared arithmetic for the phases
    logic [CW-1:0]         w_rx_inc;
    logic [CW-1:0]         w_tx_inc;
    logic                  w_timeout;
    logic [4:0]            w_shamt;
    logic [LW-1:0]         w_len_acc;
    logic [LW-1:0]         w_len_dec;
    logic                  w_last_digit;
    logic [TW-1:0]         w_tlen;
    logic [LW-1:0]         w_tlen_ext;

    assign w_rx_inc  = (r_rx_cnt == mqrx_pkg::CNT_MAX) ? r_rx_cnt : r_rx_cnt + 1'b1;
    assign w_tx_inc  = (r_tx_cnt == mqrx_pkg::CNT_MAX) ? r_tx_cnt : r_tx_cnt + 1'b1;
    assign w_timeout = (w_rx_inc > {1'b0, w_keepalive}) || (w_tx_inc > {1'b0, w_keepalive});

    // digit weight is 128^idx: shift by 7*idx = 4*idx + 2*idx + idx
    assign w_shamt      = {1'b0, r_idx, 2'b00} + {2'b00, r_idx, 1'b0} + {3'b000, r_idx};
    assign w_len_acc    = r_len + ({{(LW-7){1'b0}}, r_in_byte[6:0]} << w_shamt);
    assign w_len_dec    = r_len - 1'b1;
    assign w_last_digit = (({1'b0, r_idx} + 3'd1) >= 3'(MAX_LENGTH_BYTES));
    assign w_tlen       = {r_thi, r_in_byte};
    assign w_tlen_ext   = {{(LW-TW){1'b0}}, w_tlen};

    always_comb begin
        n_link_up   = r_link_up;
        n_ping      = r_ping;
        n_rx_cnt    = r_rx_cnt;
        n_tx_cnt    = r_tx_cnt;
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_idx       = r_idx;
        n_thi       = r_thi;
        w_res       = '0;
        w_res_valid = 1'b0;

        unique case (r_in_req)
            mqrx_pkg::REQ_CONNECT: begin
                // (re)start the session from a clean parser
                n_link_up = 1'b1;
                n_ping    = 1'b0;
                n_rx_cnt  = '0;
                n_tx_cnt  = '0;
                n_phase   = mqrx_pkg::PH_HEAD;
                n_type    = mqrx_pkg::T_NONE;
                n_len     = '0;
                n_idx     = '0;
                n_thi     = '0;
            end
            mqrx_pkg::REQ_SENT: begin
                // host activity counts even while the link is down
                n_tx_cnt = '0;
            end
            mqrx_pkg::REQ_TICK: begin
                if (r_link_up) begin
                    n_rx_cnt = w_rx_inc;
                    n_tx_cnt = w_tx_inc;
                    if (w_timeout) begin
                        w_res_valid = 1'b1;
                        if (r_ping) begin
                            // unanswered ping: drop link, counts are not cleared
                            n_link_up    = 1'b0;
                            n_phase      = mqrx_pkg::PH_HEAD;
                            n_type       = mqrx_pkg::T_NONE;
                            n_len        = '0;
                            n_idx        = '0;
                            n_thi        = '0;
                            w_res.action = mqrx_pkg::ACT_DROP;
                        end else begin
                            n_rx_cnt          = '0;
                            n_tx_cnt          = '0;
                            n_ping            = 1'b1;
                            w_res.action      = mqrx_pkg::ACT_PINGREQ;
                            w_res.packet_type = mqrx_pkg::T_PINGREQ;
                        end
                    end
                end
            end
            mqrx_pkg::REQ_BYTE: begin
                if (r_link_up) begin
                    w_res.packet_type = r_type;
                    unique case (r_phase)
                        mqrx_pkg::PH_LEN: begin
                            n_len = w_len_acc;
                            if (r_in_byte[7]) begin
                                if (w_last_digit) begin
                                    // continuation on the final allowed digit
                                    n_phase      = mqrx_pkg::PH_HEAD;
                                    n_idx        = '0;
                                    w_res_valid  = 1'b1;
                                    w_res.action = mqrx_pkg::ACT_MALFORM;
                                end else begin
                                    n_idx = r_idx + 2'd1;
                                end
                            end else begin
                                n_idx    = '0;
                                n_rx_cnt = '0;
                                n_phase  = (w_len_acc != '0) ? mqrx_pkg::PH_SKIP
                                                             : mqrx_pkg::PH_HEAD;
                                if (r_type == mqrx_pkg::T_PINGREQ) begin
                                    w_res_valid  = 1'b1;
                                    w_res.action = mqrx_pkg::ACT_PINGRESP;
                                end else if (r_type == mqrx_pkg::T_PINGRESP) begin
                                    n_ping = 1'b0;
                                end else if (r_type == mqrx_pkg::T_PUBLISH) begin
                                    if (w_len_acc < LW'(2)) begin
                                        w_res_valid  = 1'b1;
                                        w_res.action = mqrx_pkg::ACT_MALFORM;
                                    end else begin
                                        n_phase = mqrx_pkg::PH_THI;
                                    end
                                end
                            end
                        end
                        mqrx_pkg::PH_THI: begin
                            n_thi   = r_in_byte;
                            n_len   = w_len_dec;
                            n_phase = mqrx_pkg::PH_TLO;
                        end
                        mqrx_pkg::PH_TLO: begin
                            n_len       = w_len_dec;
                            w_res_valid = 1'b1;
                            if (w_tlen_ext > w_len_dec) begin
                                // topic runs past the packet: skip the rest
                                n_phase      = (w_len_dec != '0) ? mqrx_pkg::PH_SKIP
                                                                 : mqrx_pkg::PH_HEAD;
                                w_res.action = mqrx_pkg::ACT_MALFORM;
                            end else begin
                                n_phase              = (w_len_dec != '0) ? mqrx_pkg::PH_FWD
                                                                         : mqrx_pkg::PH_HEAD;
                                w_res.action         = mqrx_pkg::ACT_PUB_HEAD;
                                w_res.topic_length   = w_tlen;
                                w_res.payload_length = w_len_dec - w_tlen_ext;
                            end
                        end
                        mqrx_pkg::PH_FWD: begin
                            n_len = w_len_dec;
                            if (w_len_dec == '0) begin
                                n_phase = mqrx_pkg::PH_HEAD;
                            end
                            w_res_valid     = 1'b1;
                            w_res.action    = mqrx_pkg::ACT_PUB_BYTE;
                            w_res.data_byte = r_in_byte;
                            w_res.last      = (w_len_dec == '0);
                        end
                        mqrx_pkg::PH_SKIP: begin
                            n_len = w_len_dec;
                            if (w_len_dec == '0) begin
                                n_phase = mqrx_pkg::PH_HEAD;
                            end
                        end
                        default: begin
                            // header byte: latch type, start the length field
                            n_type  = r_in_byte[7:4];
                            n_len   = '0;
                            n_idx   = '0;
                            n_phase = mqrx_pkg::PH_LEN;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // advance state only when the held request is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_up <= 1'b0;
            r_ping    <= 1'b0;
            r_rx_cnt  <= '0;
            r_tx_cnt  <= '0;
            r_phase   <= mqrx_pkg::PH_HEAD;
            r_type    <= mqrx_pkg::T_NONE;
            r_len     <= '0;
            r_idx     <= '0;
            r_thi     <= '0;
        end else if (w_fire) begin
            r_link_up <= n_link_up;
            r_ping    <= n_ping;
            r_rx_cnt  <= n_rx_cnt;
            r_tx_cnt  <= n_tx_cnt;
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_len     <= n_len;
            r_idx     <= n_idx;
            r_thi     <= n_thi;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold until the sink takes it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_fire) begin
            r_out_v <= w_res_valid;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.action         = r_out.action;
    assign o_res.packet_type    = r_out.packet_type;
    assign o_res.topic_length   = r_out.topic_length;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.last           = r_out.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out.action != mqrx_pkg::ACT_NONE))
        else $error("result presented with no action");

    a_last_on_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.last) |-> (r_out.action == mqrx_pkg::ACT_PUB_BYTE))
        else $error("last marker on a non-forwarded result");

    a_down_parser_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_link_up |-> (r_phase == mqrx_pkg::PH_HEAD))
        else $error("parser active while link is down");

    a_drop_clears_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid && (w_res.action == mqrx_pkg::ACT_DROP)) |=> !r_link_up)
        else $error("link still up after timeout drop");

endmodule
